// ===== rtl/sdvt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdvt_pkg: VT52 screen-difference renderer package
// Console byte codes, item kinds, sequencer states and emit phases.
// ----------------------------------------------------------------------------
package sdvt_pkg;

	localparam logic [7:0] K_ESC       = 8'h1B;
	localparam logic [7:0] K_MOVE      = 8'h59; // 'Y'
	localparam logic [7:0] K_BIAS      = 8'h20; // added to row and column of a move
	localparam logic [7:0] K_REV_ON    = 8'h70; // 'p'
	localparam logic [7:0] K_REV_OFF   = 8'h71; // 'q'
	localparam logic [7:0] K_BOLD_ON   = 8'h72; // 'r'
	localparam logic [7:0] K_BOLD_OFF  = 8'h75; // 'u'
	localparam logic [7:0] K_CLEAR     = 8'h45; // 'E'
	localparam logic [7:0] K_ERASE_EOL = 8'h4B; // 'K'
	localparam logic [7:0] K_SPACE     = 8'h20;

	typedef enum logic [1:0] {
		CMD_CELL      = 2'd0,
		CMD_FRAME_END = 2'd1,
		CMD_INIT      = 2'd2,
		CMD_ERASE_ROW = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CMP   = 4'b0010,
		S_EMIT  = 4'b0100,
		S_SWEEP = 4'b1000
	} state_t;

	// Emit phases in the order they go out; a plan is a mask of these.
	typedef enum logic [6:0] {
		PH_HDR    = 7'b0000001,
		PH_MOVE_A = 7'b0000010,
		PH_REV    = 7'b0000100,
		PH_BOLD   = 7'b0001000,
		PH_CHAR   = 7'b0010000,
		PH_MOVE_B = 7'b0100000,
		PH_KILL   = 7'b1000000
	} phase_t;

endpackage

// ===== rtl/screen_diff_vt52_renderer.sv =====
// ----------------------------------------------------------------------------
// screen_diff_vt52_renderer
// Keeps a shadow of every screen cell and turns cell updates, frame ends,
// init headers and row erases into a minimal VT52 console byte stream.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  command  | cmd, row, col, char_code, attr_bits     | start & !busy takes a beat
//  console  | out_byte, last_byte                     | strobe, one cycle, no stall
//
//  A changed cell emits 1 to 9 bytes; an unchanged cell emits none and an
//  off-screen cell is dropped. Bytes leave one per cycle from a
//  single byte generator that walks the emit plan phase by phase.
//  Erase row emits 6 bytes, then sweeps the shadow row.
//  After reset the shadow memory is swept to blanks with busy high.
//  The console side cannot stall.
// ----------------------------------------------------------------------------
module screen_diff_vt52_renderer #(
	parameter int SCREEN_ROWS = 24,
	parameter int SCREEN_COLS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [4:0] row,
	input  logic [6:0] col,
	input  logic [7:0] char_code,
	input  logic [1:0] attr_bits,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       last_byte
);
	import sdvt_pkg::*;

	localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t          state_q;
	logic [6:0]      plan_q;
	logic [2:0]      byte_q;
	logic [4:0]      row_q;
	logic [6:0]      col_q;
	logic [7:0]      ch_q;
	logic [1:0]      at_q;
	logic [AW-1:0]   cell_addr_q;
	logic [4:0]      mv_row_q;
	logic [6:0]      mv_col_q;
	logic [1:0]      tgt_q;
	logic [AW-1:0]   sweep_addr_q;
	logic [AW-1:0]   sweep_end_q;
	logic            sweep_pend_q;
	logic [4:0]      cur_row_q;
	logic [6:0]      cur_col_q;
	logic            known_q;
	logic [1:0]      cur_attr_q;
	logic            strobe_q;
	logic [7:0]      out_byte_q;
	logic            last_q;

	logic [9:0]      shadow_mem [DEPTH];
	logic [9:0]      rd_q;

	logic            row_off, col_off;
	logic [AW-1:0]   in_addr, erase_base;
	logic [4:0]      row_clamp;
	logic [6:0]      col_clamp;
	logic            differ, need_move, inc_ok;
	logic [6:0]      cur_bit, plan_rest;
	phase_t          phase;
	logic [7:0]      coord, coord_sum, nb;
	logic            end_ph, final_b;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [9:0]      mem_wdata;

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	assign row_off    = {1'b0, row} >= 6'(SCREEN_ROWS);
	assign col_off    = {1'b0, col} >= 8'(SCREEN_COLS);
	assign in_addr    = AW'(32'(row) * 32'(SCREEN_COLS) + 32'(col));
	assign erase_base = AW'(32'(row) * 32'(SCREEN_COLS));
	assign row_clamp  = row_off ? 5'(SCREEN_ROWS - 1) : row;
	assign col_clamp  = col_off ? 7'(SCREEN_COLS - 1) : col;

	assign differ    = (rd_q != {at_q, ch_q});
	assign need_move = !known_q || (cur_row_q != row_q) || (cur_col_q != col_q);
	assign inc_ok    = ({1'b0, col_q} + 8'd1) < 8'(SCREEN_COLS);

	// The lowest pending bit of the plan is the phase being sent.
	assign cur_bit   = plan_q & (~plan_q + 7'd1);
	assign plan_rest = plan_q & ~cur_bit;
	assign phase     = phase_t'(cur_bit);

	// Shared adder for the row and column bytes of a cursor move.
	assign coord     = byte_q[0] ? {1'b0, mv_col_q} : {3'b000, mv_row_q};
	assign coord_sum = coord + K_BIAS;

	always_comb begin
		nb     = K_ESC;
		end_ph = 1'b1;
		unique case (phase) inside
			PH_HDR: begin
				if (byte_q[0]) begin
					nb = byte_q[2] ? K_BOLD_OFF : (byte_q[1] ? K_REV_OFF : K_CLEAR);
				end
				end_ph = (byte_q == 3'd5);
			end
			PH_MOVE_A, PH_MOVE_B: begin
				nb     = byte_q[1] ? coord_sum : (byte_q[0] ? K_MOVE : K_ESC);
				end_ph = (byte_q == 3'd3);
			end
			PH_REV: begin
				if (byte_q[0]) begin
					nb = tgt_q[0] ? K_REV_ON : K_REV_OFF;
				end
				end_ph = (byte_q == 3'd1);
			end
			PH_BOLD: begin
				if (byte_q[0]) begin
					nb = tgt_q[1] ? K_BOLD_ON : K_BOLD_OFF;
				end
				end_ph = (byte_q == 3'd1);
			end
			PH_CHAR: begin
				nb = ch_q;
			end
			PH_KILL: begin
				if (byte_q[0]) begin
					nb = K_ERASE_EOL;
				end
				end_ph = (byte_q == 3'd1);
			end
			default: begin
				nb     = K_ESC;
				end_ph = 1'b1;
			end
		endcase
	end

	assign final_b = end_ph && (plan_rest == 7'd0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = {2'b00, K_SPACE};
		if (state_q == S_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == S_CMP && differ) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr_q;
			mem_wdata = {at_q, ch_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			shadow_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= shadow_mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			plan_q       <= '0;
			byte_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			ch_q         <= '0;
			at_q         <= '0;
			cell_addr_q  <= '0;
			mv_row_q     <= '0;
			mv_col_q     <= '0;
			tgt_q        <= '0;
			sweep_addr_q <= '0;
			sweep_end_q  <= AW'(DEPTH - 1);
			sweep_pend_q <= 1'b0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			known_q      <= 1'b0;
			cur_attr_q   <= '0;
			strobe_q     <= 1'b0;
			out_byte_q   <= '0;
			last_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						row_q       <= row;
						col_q       <= col;
						ch_q        <= char_code;
						at_q        <= attr_bits;
						cell_addr_q <= in_addr;
						byte_q      <= '0;
						case (cmd_t'(cmd))
							CMD_CELL: begin
								if (!row_off && !col_off) begin
									state_q <= S_CMP;
								end
							end
							CMD_FRAME_END: begin
								plan_q     <= PH_MOVE_B | (cur_attr_q[0] ? PH_REV : 7'd0)
								              | (cur_attr_q[1] ? PH_BOLD : 7'd0);
								mv_row_q   <= row_clamp;
								mv_col_q   <= col_clamp;
								tgt_q      <= 2'b00;
								cur_row_q  <= row_clamp;
								cur_col_q  <= col_clamp;
								known_q    <= 1'b1;
								cur_attr_q <= 2'b00;
								state_q    <= S_EMIT;
							end
							CMD_INIT: begin
								plan_q     <= PH_HDR;
								cur_attr_q <= 2'b00;
								known_q    <= 1'b0;
								state_q    <= S_EMIT;
							end
							CMD_ERASE_ROW: begin
								if (!row_off) begin
									plan_q       <= PH_MOVE_A | PH_KILL;
									mv_row_q     <= row;
									mv_col_q     <= '0;
									cur_row_q    <= row;
									cur_col_q    <= '0;
									known_q      <= 1'b1;
									sweep_addr_q <= erase_base;
									sweep_end_q  <= erase_base + AW'(SCREEN_COLS - 1);
									sweep_pend_q <= 1'b1;
									state_q      <= S_EMIT;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CMP: begin
					if (!differ) begin
						state_q <= S_IDLE;
					end else begin
						plan_q     <= PH_CHAR | (need_move ? PH_MOVE_A : 7'd0)
						              | ((at_q[0] ^ cur_attr_q[0]) ? PH_REV : 7'd0)
						              | ((at_q[1] ^ cur_attr_q[1]) ? PH_BOLD : 7'd0);
						mv_row_q   <= row_q;
						mv_col_q   <= col_q;
						tgt_q      <= at_q;
						cur_attr_q <= at_q;
						cur_row_q  <= row_q;
						// Past the last column the console position is no longer known.
						cur_col_q  <= inc_ok ? col_q + 7'd1 : col_q;
						known_q    <= inc_ok;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					strobe_q   <= 1'b1;
					out_byte_q <= nb;
					last_q     <= final_b;
					if (end_ph) begin
						byte_q <= '0;
						plan_q <= plan_rest;
					end else begin
						byte_q <= byte_q + 3'd1;
					end
					if (final_b) begin
						state_q <= sweep_pend_q ? S_SWEEP : S_IDLE;
					end
				end
				S_SWEEP: begin
					if (sweep_addr_q == sweep_end_q) begin
						sweep_pend_q <= 1'b0;
						state_q      <= S_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_last_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("byte strobe follows the last beat of an item");

	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == S_EMIT))
		else $error("byte strobe without the emit state");

	a_emit_has_plan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> plan_q != 7'd0)
		else $error("emit state with an empty plan");

	a_sweep_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> sweep_addr_q <= sweep_end_q)
		else $error("shadow sweep ran past its end");

	a_last_ends_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && final_b |=> state_q != S_EMIT)
		else $error("emit continued after the final beat");

endmodule
